### rtl/spnbc_pkg.sv
// ----------------------------------------------------------------------------
// spnbc_pkg: shared types, tables and round functions
// Holds the word structs, the S-boxes and the forward and inverse round logic.
// ----------------------------------------------------------------------------
package spnbc_pkg;

	localparam int SubkeySlots = 16;

	typedef enum logic [2:0] {
		KEY_WORD0 = 3'd0,
		KEY_WORD1 = 3'd1,
		KEY_WORD2 = 3'd2,
		KEY_WORD3 = 3'd3,
		KEY_SIZE  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KS_128 = 2'd0,
		KS_192 = 2'd1,
		KS_256 = 2'd2
	} key_size_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_CRYPT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        cmd;
		logic [63:0] block_hi;
		logic [63:0] block_lo;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} out_word_t;

	localparam logic [7:0] FwdBox [256] = '{
		8'h01,8'h11,8'h91,8'hE1,8'hD1,8'hB1,8'h71,8'h61,8'hF1,8'h21,8'hC1,8'h51,8'hA1,8'h41,8'h31,8'h81,
		8'h00,8'h10,8'hE3,8'h92,8'hB5,8'hD4,8'h77,8'h66,8'h89,8'h38,8'hAB,8'h4A,8'hCD,8'h5C,8'h2F,8'hFE,
		8'h08,8'h5F,8'h3E,8'hB0,8'h1C,8'hC2,8'h83,8'hDD,8'hE8,8'hF6,8'h47,8'h79,8'h95,8'h2B,8'hAA,8'h64,
		8'h0F,8'h48,8'hD0,8'h29,8'hA3,8'h1A,8'hF2,8'hBB,8'h65,8'hCC,8'hE4,8'h3D,8'h57,8'h7E,8'h86,8'h9F,
		8'h0C,8'h2A,8'hF4,8'h1F,8'h5B,8'h90,8'hEE,8'hC5,8'h36,8'h6D,8'h73,8'h88,8'hBC,8'hA7,8'h49,8'hD2,
		8'h0A,8'h3C,8'h18,8'h85,8'hE0,8'h4D,8'h99,8'hA4,8'hB3,8'h5E,8'hDA,8'hC7,8'h72,8'hFF,8'h6B,8'h26,
		8'h06,8'h76,8'hCF,8'hA8,8'h4E,8'h59,8'h60,8'h17,8'hDC,8'h9B,8'h32,8'hF5,8'h23,8'h84,8'hED,8'hBA,
		8'h07,8'h67,8'h2D,8'h3B,8'hFA,8'h8C,8'h16,8'h70,8'h54,8'hA2,8'h98,8'hBE,8'hEF,8'hD9,8'hC3,8'h45,
		8'h0E,8'hA9,8'h62,8'h5A,8'h27,8'hBF,8'h34,8'h9C,8'hFD,8'hD5,8'h8E,8'hE6,8'h1B,8'h43,8'h78,8'hC0,
		8'h03,8'hB2,8'h87,8'hC4,8'h9D,8'h6E,8'h4B,8'hF8,8'h7A,8'hE9,8'h2C,8'hAF,8'hD6,8'h15,8'h50,8'h33,
		8'h0D,8'hFB,8'h56,8'hEC,8'h3F,8'h75,8'hB8,8'h42,8'h1E,8'h24,8'hC9,8'h93,8'h80,8'h6A,8'hD7,8'hAD,
		8'h04,8'hE5,8'hB9,8'h7D,8'h82,8'hA6,8'hCA,8'h2E,8'h97,8'h13,8'h6F,8'hDB,8'h44,8'h30,8'hFC,8'h58,
		8'h0B,8'h8D,8'h9A,8'h46,8'h74,8'h28,8'hDF,8'h53,8'hCB,8'hB7,8'hF0,8'h6C,8'hAE,8'hE2,8'h35,8'h19,
		8'h05,8'h94,8'h7B,8'hDE,8'hC6,8'hF3,8'hAC,8'h39,8'h4F,8'h8A,8'h55,8'h20,8'h68,8'hBD,8'h12,8'hE7,
		8'h02,8'hD3,8'hA5,8'hF7,8'h69,8'hEB,8'h5D,8'h8F,8'h22,8'h40,8'hB6,8'h14,8'h3A,8'hC8,8'h9E,8'h7C,
		8'h09,8'hCE,8'h4C,8'h63,8'hD8,8'h37,8'h25,8'hEA,8'hA0,8'h7F,8'h1D,8'h52,8'hF9,8'h96,8'hB4,8'h8B
	};

	localparam logic [7:0] InvBox [256] = '{
		8'h10,8'h00,8'hE0,8'h90,8'hB0,8'hD0,8'h60,8'h70,8'h20,8'hF0,8'h50,8'hC0,8'h40,8'hA0,8'h80,8'h30,
		8'h11,8'h01,8'hDE,8'hB9,8'hEB,8'h9D,8'h76,8'h67,8'h52,8'hCF,8'h35,8'h8C,8'h24,8'hFA,8'hA8,8'h43,
		8'hDB,8'h09,8'hE8,8'h6C,8'hA9,8'hF6,8'h5F,8'h84,8'hC5,8'h33,8'h41,8'h2D,8'h9A,8'h72,8'hB7,8'h1E,
		8'hBD,8'h0E,8'h6A,8'h9F,8'h86,8'hCE,8'h48,8'hF5,8'h19,8'hD7,8'hEC,8'h73,8'h51,8'h3B,8'h22,8'hA4,
		8'hE9,8'h0D,8'hA7,8'h8D,8'hBC,8'h7F,8'hC3,8'h2A,8'h31,8'h4E,8'h1B,8'h96,8'hF2,8'h55,8'h64,8'hD8,
		8'h9E,8'h0B,8'hFB,8'hC7,8'h78,8'hDA,8'hA2,8'h3C,8'hBF,8'h65,8'h83,8'h44,8'h1D,8'hE6,8'h59,8'h21,
		8'h66,8'h07,8'h82,8'hF3,8'h2F,8'h38,8'h17,8'h71,8'hDC,8'hE4,8'hAD,8'h5E,8'hCB,8'h49,8'h95,8'hBA,
		8'h77,8'h06,8'h5C,8'h4A,8'hC4,8'hA5,8'h61,8'h16,8'h8E,8'h2B,8'h98,8'hD2,8'hEF,8'hB3,8'h3D,8'hF9,
		8'hAC,8'h0F,8'hB4,8'h26,8'h6D,8'h53,8'h3E,8'h92,8'h4B,8'h18,8'hD9,8'hFF,8'h75,8'hC1,8'h8A,8'hE7,
		8'h45,8'h02,8'h13,8'hAB,8'hD1,8'h2C,8'hFD,8'hB8,8'h7A,8'h56,8'hC2,8'h69,8'h87,8'h94,8'hEE,8'h3F,
		8'hF8,8'h0C,8'h79,8'h34,8'h57,8'hE2,8'hB5,8'h4D,8'h63,8'h81,8'h2E,8'h1A,8'hD6,8'hAF,8'hCC,8'h9B,
		8'h23,8'h05,8'h91,8'h58,8'hFE,8'h14,8'hEA,8'hC9,8'hA6,8'hB2,8'h6F,8'h37,8'h4C,8'hDD,8'h7B,8'h85,
		8'h8F,8'h0A,8'h25,8'h7E,8'h93,8'h47,8'hD4,8'h5B,8'hED,8'hAA,8'hB6,8'hC8,8'h39,8'h1C,8'hF1,8'h62,
		8'h32,8'h04,8'h4F,8'hE1,8'h15,8'h89,8'h9C,8'hAE,8'hF4,8'h7D,8'h5A,8'hBB,8'h68,8'h27,8'hD3,8'hC6,
		8'h54,8'h03,8'hCD,8'h12,8'h3A,8'hB1,8'h8B,8'hDF,8'h28,8'h99,8'hF7,8'hE5,8'hA3,8'h6E,8'h46,8'h7C,
		8'hCA,8'h08,8'h36,8'hD5,8'h42,8'h6B,8'h29,8'hE3,8'h97,8'hFC,8'h74,8'hA1,8'hBE,8'h88,8'h1F,8'h5D
	};

	// Byte i of a block sits in bits 127-8i downto 120-8i.
	function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
		get_byte = v[127 - 8*i -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h2B : 8'h00);
	endfunction

	function automatic logic [127:0] sub_fwd(input logic [127:0] v);
		logic [127:0] r;
		for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = FwdBox[get_byte(v, i)];
		sub_fwd = r;
	endfunction

	function automatic logic [127:0] sub_inv(input logic [127:0] v);
		logic [127:0] r;
		for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = InvBox[get_byte(v, i)];
		sub_inv = r;
	endfunction

	function automatic logic [127:0] word_mix(input logic [127:0] v);
		logic [31:0] all;
		all = v[127:96] ^ v[95:64] ^ v[63:32] ^ v[31:0];
		word_mix = {all ^ v[127:96], all ^ v[95:64], all ^ v[63:32], all ^ v[31:0]};
	endfunction

	function automatic logic [127:0] byte_mix(input logic [127:0] v);
		logic [127:0] r;
		logic [7:0] a0, a1, a2, a3, o0, o1, o2, o3;
		for (int g = 0; g < 16; g += 4) begin
			a0 = get_byte(v, g); a1 = get_byte(v, g+1);
			a2 = get_byte(v, g+2); a3 = get_byte(v, g+3);
			o0 = a0 ^ a2 ^ a3 ^ xtime(a1 ^ a3);
			o1 = a1 ^ a3 ^ o0 ^ xtime(a2 ^ o0);
			o2 = a2 ^ o0 ^ o1 ^ xtime(a3 ^ o1);
			o3 = a3 ^ o1 ^ o2 ^ xtime(o0 ^ o2);
			r[127 - 8*g -: 32] = {o0, o1, o2, o3};
		end
		byte_mix = r;
	endfunction

	function automatic logic [127:0] byte_unmix(input logic [127:0] v);
		logic [127:0] r;
		logic [7:0] a0, a1, a2, a3, o0, o1, o2, o3;
		for (int g = 0; g < 16; g += 4) begin
			a0 = get_byte(v, g); a1 = get_byte(v, g+1);
			a2 = get_byte(v, g+2); a3 = get_byte(v, g+3);
			o3 = a1 ^ a2 ^ a3 ^ xtime(a0 ^ a2);
			o2 = a0 ^ a1 ^ a2 ^ xtime(a1 ^ o3);
			o1 = o3 ^ a0 ^ a1 ^ xtime(a0 ^ o2);
			o0 = a0 ^ o2 ^ o3 ^ xtime(o1 ^ o3);
			r[127 - 8*g -: 32] = {o0, o1, o2, o3};
		end
		byte_unmix = r;
	endfunction

endpackage

### rtl/spn_block_cipher_128.sv
// ----------------------------------------------------------------------------
// spn_block_cipher_128: 128-bit SPN block cipher, iterative
// Rounds: 6, 7 or 8 for 128-, 192- or 256-bit keys, between a load and an
// output step; after a key write, the first word first runs key expansion in
// four phases per round. The single shared round unit takes one word at a time.
// Reset clears the key registers, key size and the subkey-ready flag.
// ----------------------------------------------------------------------------
module spn_block_cipher_128 #(
	parameter int SUBKEY_SLOTS = spnbc_pkg::SubkeySlots
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [63:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  spnbc_pkg::in_word_t   in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output spnbc_pkg::out_word_t  out_word
);

	localparam int SlotW = $clog2(SUBKEY_SLOTS);

	// Key registers as written through the configuration port.
	logic [63:0] key0_q, key1_q, key2_q, key3_q;
	logic [1:0]  ksize_q;
	logic        ready_q;

	// Subkey store, written at load and during expansion; two slots are read per round.
	logic [127:0] subkey_q [SUBKEY_SLOTS];
	logic [127:0] white_q;

	spnbc_pkg::state_t state_q, state_d;
	logic         cmd_q;
	logic [127:0] data_q;
	logic [127:0] left_q, right_q, t2_q;
	logic [1:0]   phase_q;   // expansion sub-step within one round pair
	logic [3:0]   rnd_q;     // round counter
	logic [3:0]   nr;

	always_comb begin
		case (ksize_q)
			spnbc_pkg::KS_128: nr = 4'd6;
			spnbc_pkg::KS_192: nr = 4'd7;
			default:           nr = 4'd8;
		endcase
	end

	// Round unit operand selection. During expansion the unit computes four
	// forward rounds per step: left with the odd counter, then a keyless round,
	// then the same on right with the even counter.
	logic         ru_inv;
	logic [127:0] ru_din, ru_ka, ru_kb, ru_out;
	logic [4:0]   hi_idx;

	always_comb begin
		hi_idx = 5'(2 * nr - 1 - 2 * rnd_q);
		ru_inv = 1'b0;
		ru_din = data_q;
		ru_ka  = '0;
		ru_kb  = '0;
		if (state_q == spnbc_pkg::ST_EXPAND) begin
			case (phase_q)
				2'd0: begin
					ru_din = left_q;
					ru_ka  = {120'd0, 3'd0, rnd_q, 1'b1};
				end
				2'd2: begin
					ru_din = right_q;
					ru_ka  = {120'd0, 3'd0, rnd_q + 4'd1, 1'b0};
				end
				default: ru_din = data_q;
			endcase
		end else if (cmd_q) begin
			ru_inv = 1'b1;
			ru_ka  = subkey_q[hi_idx[SlotW-1:0]];
			ru_kb  = subkey_q[SlotW'(hi_idx - 5'd1)];
		end else begin
			ru_ka = subkey_q[SlotW'({rnd_q, 1'b0})];
			ru_kb = subkey_q[SlotW'({rnd_q, 1'b1})];
		end
	end

	spnbc_round u_round (
		.inv  (ru_inv),
		.din  (ru_din),
		.ka   (ru_ka),
		.kb   (ru_kb),
		.dout (ru_out)
	);

	logic last_rnd;
	assign last_rnd = (rnd_q == nr - 4'd1);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			spnbc_pkg::ST_IDLE:
				if (in_valid) state_d = ready_q ? spnbc_pkg::ST_CRYPT : spnbc_pkg::ST_EXPAND;
			spnbc_pkg::ST_EXPAND:
				if (phase_q == 2'd3 && last_rnd) state_d = spnbc_pkg::ST_CRYPT;
			spnbc_pkg::ST_CRYPT:
				if (last_rnd) state_d = spnbc_pkg::ST_DONE;
			spnbc_pkg::ST_DONE:
				if (!out_stall) state_d = spnbc_pkg::ST_IDLE;
			default: state_d = spnbc_pkg::ST_IDLE;
		endcase
	end

	// Output logic.
	always_comb begin
		in_stall  = (state_q != spnbc_pkg::ST_IDLE);
		out_valid = (state_q == spnbc_pkg::ST_DONE);
		out_word  = {data_q[127:64], data_q[63:0]};
	end

	// Key expansion seed, with the short-key fill.
	logic [127:0] seed_l, seed_r;
	always_comb begin
		seed_l = {key0_q, key1_q};
		case (ksize_q)
			spnbc_pkg::KS_128: seed_r = ~{key0_q, key1_q};
			spnbc_pkg::KS_192: seed_r = {key2_q, ~key1_q};
			default:           seed_r = {key2_q, key3_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spnbc_pkg::ST_IDLE;
			key0_q  <= '0;
			key1_q  <= '0;
			key2_q  <= '0;
			key3_q  <= '0;
			ksize_q <= '0;
			ready_q <= 1'b0;
			phase_q <= '0;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					spnbc_pkg::KEY_WORD0: begin key0_q <= cfg_data; ready_q <= 1'b0; end
					spnbc_pkg::KEY_WORD1: begin key1_q <= cfg_data; ready_q <= 1'b0; end
					spnbc_pkg::KEY_WORD2: begin key2_q <= cfg_data; ready_q <= 1'b0; end
					spnbc_pkg::KEY_WORD3: begin key3_q <= cfg_data; ready_q <= 1'b0; end
					spnbc_pkg::KEY_SIZE:  begin ksize_q <= cfg_data[1:0]; ready_q <= 1'b0; end
					default: ;
				endcase
			end
			case (state_q)
				spnbc_pkg::ST_IDLE: begin
					phase_q <= '0;
					rnd_q   <= '0;
				end
				spnbc_pkg::ST_EXPAND: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd3) begin
						rnd_q <= last_rnd ? 4'd0 : rnd_q + 4'd1;
						if (last_rnd) ready_q <= 1'b1;
					end
				end
				spnbc_pkg::ST_CRYPT: rnd_q <= last_rnd ? 4'd0 : rnd_q + 4'd1;
				default: ;
			endcase
		end
	end

	// Datapath registers.
	logic [4:0] odd_idx;
	assign odd_idx = {rnd_q, 1'b1};

	always_ff @(posedge clk) begin
		case (state_q)
			spnbc_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd_q   <= in_word.cmd;
					left_q  <= seed_l;
					right_q <= seed_r;
					if (!ready_q)
						data_q <= {in_word.block_hi, in_word.block_lo};
					else if (in_word.cmd)
						data_q <= {in_word.block_hi, in_word.block_lo} ^ white_q;
					else
						data_q <= {in_word.block_hi, in_word.block_lo};
					if (!ready_q) begin
						t2_q <= {in_word.block_hi, in_word.block_lo};
						subkey_q[0] <= seed_l;
					end
				end
			end
			spnbc_pkg::ST_EXPAND: begin
				case (phase_q)
					2'd0: data_q <= ru_out;
					2'd1: begin
						// t2 holds the block while data carries the key path.
						left_q <= ru_out;
						data_q <= ru_out;
					end
					2'd2: data_q <= ru_out;
					default: begin
						left_q  <= ru_out;
						right_q <= ru_out ^ left_q;
						subkey_q[SlotW'(odd_idx)] <= ru_out;
						if (last_rnd) begin
							white_q <= ru_out ^ left_q;
							data_q  <= cmd_q ? t2_q ^ ru_out ^ left_q : t2_q;
						end else begin
							subkey_q[SlotW'(odd_idx + 5'd1)] <= ru_out ^ left_q;
							data_q <= ru_out;
						end
					end
				endcase
			end
			spnbc_pkg::ST_CRYPT: begin
				if (last_rnd && !cmd_q) data_q <= ru_out ^ white_q;
				else data_q <= ru_out;
			end
			default: ;
		endcase
	end

endmodule

### rtl/spnbc_round.sv
// ----------------------------------------------------------------------------
// spnbc_round: shared round unit
// One forward or inverse round per cycle, purely combinational.
// ----------------------------------------------------------------------------
module spnbc_round (
	input  logic         inv,
	input  logic [127:0] din,
	input  logic [127:0] ka,
	input  logic [127:0] kb,
	output logic [127:0] dout
);

	logic [127:0] fwd_out;
	logic [127:0] inv_out;

	always_comb begin
		fwd_out = spnbc_pkg::word_mix(spnbc_pkg::sub_fwd(
			spnbc_pkg::byte_mix(spnbc_pkg::sub_fwd(din ^ ka)) ^ kb));
		inv_out = spnbc_pkg::sub_inv(spnbc_pkg::byte_unmix(
			spnbc_pkg::sub_inv(spnbc_pkg::word_mix(din)) ^ ka)) ^ kb;
		dout = inv ? inv_out : fwd_out;
	end

endmodule
